// File: rtl/core/rbpd_pkg.sv
`default_nettype none
package rbpd_pkg;

  localparam int unsigned RING_DEPTH = 2048;
  localparam int unsigned PACKET_MAX = 64;

  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned RD_W  = IDX_W + 1;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned WB_W  = 5;

  localparam logic [WB_W-1:0] WORD_BITS_7     = 5'd7;
  localparam logic [WB_W-1:0] WORD_BITS_8     = 5'd8;
  localparam logic [WB_W-1:0] WORD_BITS_RESET = 5'd8;
  localparam logic [7:0]      SEVEN_BIT_MASK  = 8'h7F;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POLL = 2'd1,
    FUNC_DONE = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_in;
  } in_t;

  typedef struct packed {
    logic [7:0]       byte_out;
    logic [LEN_W-1:0] chunk_len;
    logic             last;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] chunk_len;
    logic             last;
  } emit_t;

endpackage
`default_nettype wire

// File: rtl/core/rbpd_ram.sv
`default_nettype none
module rbpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rbpd_seq.sv
`default_nettype none
module rbpd_seq
  import rbpd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire in_t             in_data_i,
  input  wire logic [WB_W-1:0] word_bits_i,
  input  wire logic            out_stall_i,
  output logic                 in_stall_o,
  output ram_req_t             ram_req_o,
  output emit_t                emit_o
);

  localparam logic [RD_W-1:0]  DEPTH_RD  = RD_W'(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_DEPTH - 1);
  localparam logic [RD_W-1:0]  PKT_RD    = RD_W'(PACKET_MAX);
  localparam logic [LEN_W-1:0] PKT_LEN   = LEN_W'(PACKET_MAX);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] wr_q, wr_d;
  logic [RD_W-1:0]  rd_q, rd_d;
  logic             busy_q, busy_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  logic             in_acc;
  logic             out_acc;
  logic             is_last;
  logic             empty;
  logic [RD_W-1:0]  wr_ext;
  logic [RD_W-1:0]  avail;
  logic [LEN_W-1:0] len_calc;
  logic [RD_W-1:0]  rd_inc;
  logic [LEN_W-1:0] cnt_inc;

  assign in_acc  = in_valid_i && (state_q == ST_IDLE);
  assign out_acc = (state_q == ST_EMIT) && !out_stall_i;
  assign rd_inc  = rd_q + RD_W'(1);
  assign cnt_inc = cnt_q + LEN_W'(1);
  assign is_last = (cnt_inc == len_q);

  // Chunk length: stop at the write index, at the wrap point or at PACKET_MAX bytes.
  assign wr_ext   = {1'b0, wr_q};
  assign empty    = (rd_q == wr_ext);
  assign avail    = (rd_q > wr_ext) ? (DEPTH_RD - rd_q) : (wr_ext - rd_q);
  assign len_calc = (avail > PKT_RD) ? PKT_LEN : LEN_W'(avail);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && (in_data_i.func == FUNC_POLL) && !busy_q) state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = empty ? ST_IDLE : ST_READ;
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc && is_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    busy_d = busy_q;
    len_d  = len_q;
    cnt_d  = cnt_q;
    clr_d  = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + IDX_W'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.func)
            FUNC_PUSH: wr_d = (wr_q == LAST_IDX) ? '0 : wr_q + IDX_W'(1);
            FUNC_POLL: begin
              // fold a read index resting at the wrap point
              if (!busy_q && (rd_q >= DEPTH_RD)) rd_d = '0;
            end
            FUNC_DONE: busy_d = 1'b0;
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        busy_d = !empty;
        len_d  = len_calc;
        cnt_d  = '0;
      end
      ST_READ: ;
      ST_EMIT: begin
        if (out_acc) begin
          rd_d  = rd_inc;
          cnt_d = cnt_inc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    ram_req_o       = '0;
    emit_o.valid    = (state_q == ST_EMIT);
    emit_o.chunk_len = len_q;
    emit_o.last     = is_last;
    unique case (state_q)
      ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_q;
      end
      ST_IDLE: begin
        ram_req_o.waddr = wr_q;
        if (in_acc && (in_data_i.func == FUNC_PUSH)) begin
          if (word_bits_i == WORD_BITS_7) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.wdata = in_data_i.byte_in & SEVEN_BIT_MASK;
          end else if (word_bits_i == WORD_BITS_8) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.wdata = in_data_i.byte_in;
          end
        end
      end
      ST_CALC: ;
      ST_READ: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = rd_q[IDX_W-1:0];
      end
      ST_EMIT: begin
        // fetch the next byte as the current one leaves
        ram_req_o.re    = out_acc && !is_last;
        ram_req_o.raddr = rd_inc[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      wr_q    <= '0;
      rd_q    <= '0;
      busy_q  <= 1'b0;
      len_q   <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      busy_q  <= busy_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ring_buffer_packet_drain.sv
`default_nettype none
// Channel  Direction  Payload  Handshake
// in       input      in_t     in_valid_i / in_stall_o
// out      output     out_t    out_valid_o / out_stall_i
// cfg      input      5 bits   cfg_we_i (word_bits, no read-back)
//
// After reset a clearing pass zeroes the ring, one byte per cycle, with
// the input stalled; cfg writes are taken throughout. Push, done, ignored
// and busy-poll items are taken in idle; an empty poll goes through calc
// back to idle, a draining poll through calc, read and emit. The single
// RAM read port sets the byte rate. A stall on the output holds the
// current item in the RAM read register.
module ring_buffer_packet_drain
  import rbpd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire in_t             in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output out_t                 out_data_o,
  input  wire logic            cfg_we_i,
  input  wire logic [WB_W-1:0] cfg_wdata_i
);

  logic [WB_W-1:0] word_bits_q;
  ram_req_t        ram_req;
  emit_t           emit;
  logic [7:0]      ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_bits_q <= WORD_BITS_RESET;
    end else if (cfg_we_i) begin
      word_bits_q <= cfg_wdata_i;
    end
  end

  rbpd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .word_bits_i (word_bits_q),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .ram_req_o   (ram_req),
    .emit_o      (emit)
  );

  rbpd_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o          = emit.valid;
  assign out_data_o.byte_out  = ram_rdata;
  assign out_data_o.chunk_len = emit.chunk_len;
  assign out_data_o.last      = emit.last;

`ifndef SYNTHESIS
  a_no_accept_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o && out_valid_o))
    else $error("input item accepted while a chunk is draining");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last) |=> (!out_valid_o && !in_stall_o))
    else $error("block did not return to idle after last byte");

  a_chunk_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last) |=> out_valid_o)
    else $error("chunk ended before its last byte");

  a_len_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |=> $stable(out_data_o.chunk_len))
    else $error("chunk length changed inside a chunk");
`endif

endmodule
`default_nettype wire

// File: tb/ring_buffer_packet_drain_checker.sv
`timescale 1ns / 1ps
module ring_buffer_packet_drain_checker
  import rbpd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_stall_i,
  input  wire in_t             in_data_i,
  input  wire logic            out_valid_i,
  input  wire logic            out_stall_i,
  input  wire out_t            out_data_i,
  input  wire logic            cfg_we_i,
  input  wire logic [WB_W-1:0] cfg_wdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          bytes_checked_o,
  output int unsigned          chunks_checked_o
);

  logic [7:0]       ring_mem [RING_DEPTH];
  logic [IDX_W-1:0] wr_idx;
  logic [RD_W-1:0]  rd_idx;
  logic             tx_busy;
  logic [WB_W-1:0]  word_bits;
  out_t             chunk_bytes_q [$];
  int unsigned      mismatches;
  int unsigned      bytes_checked;
  int unsigned      chunks_checked;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic store_byte(logic [7:0] b);
    if (word_bits == WORD_BITS_7) begin
      ring_mem[wr_idx] = b & SEVEN_BIT_MASK;
    end else if (word_bits == WORD_BITS_8) begin
      ring_mem[wr_idx] = b;
    end
    // other word sizes leave the slot alone but still advance
    if (wr_idx == IDX_W'(RING_DEPTH - 1)) begin
      wr_idx = '0;
    end else begin
      wr_idx = wr_idx + 1'b1;
    end
  endtask

  task automatic predict_chunk();
    int unsigned rd;
    int unsigned avail;
    int unsigned len;
    int unsigned k;
    out_t        b;
    if (tx_busy) begin
      return;
    end
    rd = rd_idx;
    // fold a read index left at the end of the ring
    if (rd >= RING_DEPTH) begin
      rd = 0;
    end
    rd_idx = RD_W'(rd);
    if (rd == wr_idx) begin
      tx_busy = 1'b0;
      return;
    end
    // stop the chunk at the wrap point
    if (rd > wr_idx) begin
      avail = RING_DEPTH - rd;
    end else begin
      avail = wr_idx - rd;
    end
    len = (avail > PACKET_MAX) ? PACKET_MAX : avail;
    for (k = 0; k < len; k++) begin
      b.byte_out  = ring_mem[(rd + k) % RING_DEPTH];
      b.chunk_len = len[LEN_W-1:0];
      b.last      = (k + 1 == len);
      chunk_bytes_q.push_back(b);
    end
    rd_idx  = RD_W'(rd + len);
    tx_busy = 1'b1;
  endtask

  task automatic apply_item(in_t item);
    case (item.func)
      FUNC_PUSH: store_byte(item.byte_in);
      FUNC_POLL: predict_chunk();
      FUNC_DONE: tx_busy = 1'b0;
      default: ;
    endcase
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (chunk_bytes_q.size() == 0) begin
      report_mismatch("unexpected item", got, 0);
      return;
    end
    want = chunk_bytes_q.pop_front();
    if (got.byte_out !== want.byte_out) begin
      report_mismatch("byte_out", got.byte_out, want.byte_out);
    end
    if (got.chunk_len !== want.chunk_len) begin
      report_mismatch("chunk_len", got.chunk_len, want.chunk_len);
    end
    if (got.last !== want.last) begin
      report_mismatch("last", got.last, want.last);
    end
    bytes_checked++;
    if (want.last) begin
      chunks_checked++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_mem[i] = '0;
      end
      wr_idx         = '0;
      rd_idx         = '0;
      tx_busy        = 1'b0;
      word_bits      = WORD_BITS_RESET;
      mismatches     = 0;
      bytes_checked  = 0;
      chunks_checked = 0;
      chunk_bytes_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
      // an item taken at this edge still sees the old word size
      if (in_valid_i && !in_stall_i) begin
        apply_item(in_data_i);
      end
      if (cfg_we_i) begin
        word_bits = cfg_wdata_i;
      end
    end
    fail_count_o     <= mismatches;
    pending_o        <= chunk_bytes_q.size();
    bytes_checked_o  <= bytes_checked;
    chunks_checked_o <= chunks_checked;
  end

endmodule

// File: tb/tb_ring_buffer_packet_drain.sv
`timescale 1ns / 1ps
module tb_ring_buffer_packet_drain
  import rbpd_pkg::*;
();

  localparam int unsigned      QUIET_LIMIT    = 10000;
  localparam int unsigned      HOLD_CYCLES    = 400;
  localparam int unsigned      SETTLE_CYCLES  = 100;
  localparam logic [1:0]       FUNC_UNUSED    = 2'd3;
  localparam logic [WB_W-1:0]  WORD_BITS_MIN  = 5'd5;
  localparam logic [WB_W-1:0]  WORD_BITS_MAX  = 5'd16;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_t             in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_t            out_data;
  logic            cfg_we    = 1'b0;
  logic [WB_W-1:0] cfg_wdata = WORD_BITS_RESET;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_checked;
  int unsigned chunks_checked;

  bit          idle_en      = 1'b0;
  bit          long_hold    = 1'b0;
  int unsigned items_sent   = 0;
  int unsigned backlog      = 0;
  int unsigned settings_run = 0;
  int unsigned quiet_cycles = 0;

  ring_buffer_packet_drain dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  ring_buffer_packet_drain_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .bytes_checked_o  (bytes_checked),
    .chunks_checked_o (chunks_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: one long hold on request, else random stall bursts while idle_en is set
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(logic [1:0] f, logic [7:0] b);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {f, b};
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
    if (f == FUNC_PUSH) begin
      if (backlog < RING_DEPTH) begin
        backlog++;
      end
    end
  endtask

  // hold the input until every chunk is out and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_word_bits(logic [WB_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // enough done/poll pairs to read out anything still in the ring
  task automatic empty_ring();
    repeat (backlog / PACKET_MAX + 2) begin
      send_item(FUNC_DONE, rand_byte());
      send_item(FUNC_POLL, rand_byte());
    end
    send_item(FUNC_DONE, rand_byte());
    backlog = 0;
  endtask

  task automatic run_traffic(int unsigned quota);
    int unsigned stop_at;
    int unsigned n;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 140) : $urandom_range(1, 40);
        if (n > stop_at - items_sent) begin
          n = stop_at - items_sent;
        end
        repeat (n) send_item(FUNC_PUSH, rand_byte());
        repeat ($urandom_range(1, 3)) begin
          send_item(FUNC_POLL, rand_byte());
          if ($urandom_range(0, 3) == 0) begin
            send_item(FUNC_POLL, rand_byte());
          end
          send_item(FUNC_DONE, rand_byte());
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), rand_byte());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset word size: whole bytes, then busy, ignored and empty polls
    send_item(FUNC_PUSH, 8'h00);
    send_item(FUNC_PUSH, 8'hFF);
    send_item(FUNC_PUSH, 8'hA5);
    send_item(FUNC_PUSH, 8'h5A);
    send_item(FUNC_POLL, 8'h00);
    send_item(FUNC_POLL, 8'hFF);
    send_item(FUNC_UNUSED, 8'hFF);
    send_item(FUNC_DONE, 8'h00);
    send_item(FUNC_POLL, 8'h00);
    send_item(FUNC_POLL, 8'h00);
    send_item(FUNC_DONE, 8'hFF);

    set_word_bits(WORD_BITS_7);
    send_item(FUNC_PUSH, 8'hFF);
    send_item(FUNC_PUSH, 8'h80);
    send_item(FUNC_PUSH, 8'h7F);
    send_item(FUNC_POLL, 8'h00);
    send_item(FUNC_DONE, 8'h00);

    // no store: slots keep their cleared content
    set_word_bits(WORD_BITS_MIN);
    send_item(FUNC_PUSH, 8'hC3);
    send_item(FUNC_PUSH, 8'h11);
    send_item(FUNC_POLL, 8'h00);
    send_item(FUNC_DONE, 8'h00);

    set_word_bits(WORD_BITS_MAX);
    send_item(FUNC_PUSH, 8'h99);
    send_item(FUNC_POLL, 8'h00);
    send_item(FUNC_DONE, 8'h00);

    // back-pressure: hold the output while a full chunk drains, keep offering
    set_word_bits(WORD_BITS_8);
    long_hold = 1'b1;
    repeat (70) send_item(FUNC_PUSH, rand_byte());
    send_item(FUNC_POLL, rand_byte());
    repeat (20) send_item(FUNC_PUSH, rand_byte());
    send_item(FUNC_DONE, rand_byte());
    send_item(FUNC_POLL, rand_byte());
    send_item(FUNC_DONE, rand_byte());
    backlog = 30;

    idle_en = 1'b1;
    set_word_bits(WORD_BITS_7);
    run_traffic(60);
    set_word_bits(WORD_BITS_MIN);
    run_traffic(50);

    // read out everything that is left, down to an empty ring
    set_word_bits(WORD_BITS_MAX);
    run_traffic(40);
    empty_ring();

    set_word_bits(WB_W'($urandom_range(WORD_BITS_MIN, WORD_BITS_MAX)));
    run_traffic(50);

    set_word_bits(WORD_BITS_8);
    run_traffic(50);
    empty_ring();

    idle_en = 1'b0;
    run_traffic(60);

    wait_idle();
    $display("Sent %0d items over %0d word-size settings, with full and empty drains;",
             items_sent, settings_run);
    $display("checked %0d bytes in %0d chunks, %0d mismatches.",
             bytes_checked, chunks_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rbpd_pkg.sv
rtl/core/rbpd_ram.sv
rtl/core/rbpd_seq.sv
rtl/core/ring_buffer_packet_drain.sv
tb/ring_buffer_packet_drain_checker.sv
tb/tb_ring_buffer_packet_drain.sv
